// ===== design/e2q_pkg.sv =====
package e2q_pkg;

    localparam int ANGLE_WIDTH       = 16;
    localparam int OUT_FRACTION_BITS = 14;
    localparam int CORDIC_STAGES     = 16;
    localparam int QX_FRAC           = 30;
    localparam int Z_WIDTH           = 34;
    localparam int XY_WIDTH          = 33;
    localparam int OUT_WIDTH         = 16;
    localparam int STAGE_IDX_WIDTH   = $clog2(CORDIC_STAGES);
    localparam logic signed [XY_WIDTH-1:0] CORDIC_GAIN_Q30 = 33'sd652032874;

    typedef struct packed {
        logic signed [XY_WIDTH-1:0] x;
        logic signed [XY_WIDTH-1:0] y;
        logic signed [Z_WIDTH-1:0]  z;
    } rot_t;

    typedef struct packed {
        rot_t roll;
        rot_t pitch;
        rot_t yaw;
    } trio_t;

    function automatic logic [31:0] atan_step(input logic [4:0] idx);
        logic [31:0] v;
        begin
            case (idx)
                5'd0:  v = 32'h20000000;
                5'd1:  v = 32'h12E4051E;
                5'd2:  v = 32'h09FB385B;
                5'd3:  v = 32'h051111D4;
                5'd4:  v = 32'h028B0D43;
                5'd5:  v = 32'h0145D7E1;
                5'd6:  v = 32'h00A2F61E;
                5'd7:  v = 32'h00517C55;
                5'd8:  v = 32'h0028BE53;
                5'd9:  v = 32'h00145F2F;
                5'd10: v = 32'h000A2F98;
                5'd11: v = 32'h000517CC;
                5'd12: v = 32'h00028BE6;
                5'd13: v = 32'h000145F3;
                5'd14: v = 32'h0000A2FA;
                5'd15: v = 32'h0000517D;
                5'd16: v = 32'h000028BE;
                5'd17: v = 32'h0000145F;
                5'd18: v = 32'h00000A30;
                5'd19: v = 32'h00000518;
                5'd20: v = 32'h0000028C;
                5'd21: v = 32'h00000146;
                5'd22: v = 32'h000000A3;
                5'd23: v = 32'h00000051;
                5'd24: v = 32'h00000029;
                5'd25: v = 32'h00000014;
                5'd26: v = 32'h0000000A;
                5'd27: v = 32'h00000005;
                5'd28: v = 32'h00000003;
                5'd29: v = 32'h00000001;
                5'd30: v = 32'h00000001;
                default: v = 32'h00000000;
            endcase
            return v;
        end
    endfunction

    // round Q60 sum to output fraction, clamp to +-1
    function automatic logic signed [OUT_WIDTH-1:0] finish(input logic signed [63:0] q60);
        localparam int SH = 2 * QX_FRAC - OUT_FRACTION_BITS;
        logic signed [64:0] t;
        logic signed [64:0] one;
        begin
            one = 65'sd1 <<< OUT_FRACTION_BITS;
            t = ($signed({q60[63], q60}) + (65'sd1 <<< (SH - 1))) >>> SH;
            if (t > one) t = one;
            if (t < -one) t = -one;
            return t[OUT_WIDTH-1:0];
        end
    endfunction

endpackage

// ===== design/e2q_cordic_cell.sv =====
module e2q_cordic_cell
    import e2q_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       en,
    input  logic [STAGE_IDX_WIDTH-1:0] idx,
    input  logic                       vld_in,
    input  trio_t                      d_in,
    output logic                       vld_out,
    output trio_t                      d_out
);

    logic  vld_reg;
    trio_t d_reg;
    trio_t d_next;

    function automatic rot_t rotate(input rot_t r, input logic [STAGE_IDX_WIDTH-1:0] i);
        logic signed [XY_WIDTH-1:0] dx;
        logic signed [XY_WIDTH-1:0] dy;
        logic signed [Z_WIDTH-1:0]  da;
        rot_t o;
        begin
            dx = r.y >>> i;
            dy = r.x >>> i;
            da = $signed({1'b0, atan_step(5'(i)), 1'b0});
            if (!r.z[Z_WIDTH-1]) begin
                o.x = r.x - dx;
                o.y = r.y + dy;
                o.z = r.z - da;
            end
            else begin
                o.x = r.x + dx;
                o.y = r.y - dy;
                o.z = r.z + da;
            end
            return o;
        end
    endfunction

    always_comb
    begin
        d_next.roll  = rotate(d_in.roll, idx);
        d_next.pitch = rotate(d_in.pitch, idx);
        d_next.yaw   = rotate(d_in.yaw, idx);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else if (en)
            vld_reg <= vld_in;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            d_reg <= d_next;
    end

    assign vld_out = vld_reg;
    assign d_out   = d_reg;

endmodule

// ===== design/e2q_product.sv =====
module e2q_product
    import e2q_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       en,
    input  logic                       vld_in,
    input  trio_t                      d_in,
    output logic                       vld_out,
    output logic signed [OUT_WIDTH-1:0] w,
    output logic signed [OUT_WIDTH-1:0] x,
    output logic signed [OUT_WIDTH-1:0] y,
    output logic signed [OUT_WIDTH-1:0] z
);

    // stage 1: pair products
    logic [2:0] vld_reg;
    logic signed [XY_WIDTH-1:0] cy_reg, sy_reg;
    logic signed [63:0] crcp_reg, srsp_reg, srcp_reg, crsp_reg;
    logic signed [63:0] t_reg [8];
    logic signed [OUT_WIDTH-1:0] w_reg, x_reg, y_reg, z_reg;

    function automatic logic signed [63:0] pair(input logic signed [XY_WIDTH-1:0] a,
                                                input logic signed [XY_WIDTH-1:0] b);
        logic signed [65:0] p;
        begin
            p = ($signed({{33{a[XY_WIDTH-1]}}, a}) * $signed({{33{b[XY_WIDTH-1]}}, b})
                 + (66'sd1 <<< (QX_FRAC - 1))) >>> QX_FRAC;
            return p[63:0];
        end
    endfunction

    // pair product stays within +-1.0 in Q30, so it fits an XY-wide operand
    function automatic logic signed [63:0] mul(input logic signed [63:0] a,
                                               input logic signed [XY_WIDTH-1:0] b);
        logic signed [XY_WIDTH-1:0]   aa;
        logic signed [2*XY_WIDTH-1:0] p;
        begin
            aa = a[XY_WIDTH-1:0];
            p  = aa * b;
            return p[63:0];
        end
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[1:0], vld_in};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            crcp_reg <= pair(d_in.roll.x, d_in.pitch.x);
            srsp_reg <= pair(d_in.roll.y, d_in.pitch.y);
            srcp_reg <= pair(d_in.roll.y, d_in.pitch.x);
            crsp_reg <= pair(d_in.roll.x, d_in.pitch.y);
            cy_reg   <= d_in.yaw.x;
            sy_reg   <= d_in.yaw.y;
            t_reg[0] <= mul(crcp_reg, cy_reg);
            t_reg[1] <= mul(srsp_reg, sy_reg);
            t_reg[2] <= mul(srcp_reg, cy_reg);
            t_reg[3] <= mul(crsp_reg, sy_reg);
            t_reg[4] <= mul(crsp_reg, cy_reg);
            t_reg[5] <= mul(srcp_reg, sy_reg);
            t_reg[6] <= mul(crcp_reg, sy_reg);
            t_reg[7] <= mul(srsp_reg, cy_reg);
            w_reg <= finish(t_reg[0] + t_reg[1]);
            x_reg <= finish(t_reg[2] - t_reg[3]);
            y_reg <= finish(t_reg[4] + t_reg[5]);
            z_reg <= finish(t_reg[6] - t_reg[7]);
        end
    end

    assign vld_out = vld_reg[2];
    assign w = w_reg;
    assign x = x_reg;
    assign y = y_reg;
    assign z = z_reg;

endmodule

// ===== design/euler_to_quaternion_top.sv =====
// euler_to_quaternion_top: roll/pitch/yaw binary angles to unit quaternion, Q1.14.
// Pipeline: CORDIC_STAGES cells, then 3 product stages, valid in to valid out.
// Throughput: one word per cycle; the whole pipe advances when the output is free.
// Stall from downstream freezes every stage; the output register holds its word.
// Reset (rst_n, async, active low) clears all valid bits; payload is not reset.
module euler_to_quaternion_top
    import e2q_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic signed [ANGLE_WIDTH-1:0] roll_angle,
    input  logic signed [ANGLE_WIDTH-1:0] pitch_angle,
    input  logic signed [ANGLE_WIDTH-1:0] yaw_angle,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic signed [OUT_WIDTH-1:0] quat_w,
    output logic signed [OUT_WIDTH-1:0] quat_x,
    output logic signed [OUT_WIDTH-1:0] quat_y,
    output logic signed [OUT_WIDTH-1:0] quat_z
);

    // pipe moves whenever the output stage is empty or being taken
    logic  en;
    logic  vld [CORDIC_STAGES+1];
    trio_t dat [CORDIC_STAGES+1];

    assign en       = !(out_valid && out_stall);
    assign in_stall = !en;

    // half angle in units of pi/2^32: angle << (32 - ANGLE_WIDTH), sign-extended
    function automatic rot_t seed(input logic signed [ANGLE_WIDTH-1:0] a);
        rot_t r;
        begin
            r.x = CORDIC_GAIN_Q30;
            r.y = '0;
            r.z = $signed({{(Z_WIDTH-32){a[ANGLE_WIDTH-1]}}, a, {(32-ANGLE_WIDTH){1'b0}}});
            return r;
        end
    endfunction

    assign vld[0]       = in_valid;
    assign dat[0].roll  = seed(roll_angle);
    assign dat[0].pitch = seed(pitch_angle);
    assign dat[0].yaw   = seed(yaw_angle);

    // chain of CORDIC cells, one micro-rotation per cell for all three angles
    for (genvar i = 0; i < CORDIC_STAGES; i++)
    begin : g_cell
        e2q_cordic_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .en      (en),
            .idx     (STAGE_IDX_WIDTH'(i)),
            .vld_in  (vld[i]),
            .d_in    (dat[i]),
            .vld_out (vld[i+1]),
            .d_out   (dat[i+1])
        );
    end

    e2q_product u_prod (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .vld_in  (vld[CORDIC_STAGES]),
        .d_in    (dat[CORDIC_STAGES]),
        .vld_out (out_valid),
        .w       (quat_w),
        .x       (quat_x),
        .y       (quat_y),
        .z       (quat_z)
    );

    // a stalled word holds at the output (checked on quat_w and quat_z)
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(quat_w) && $stable(quat_z))
        else $error("output word changed under stall");

    // input is refused exactly when the output is held
    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall == (out_valid && out_stall))
        else $error("input stall mismatch");

    // quat_w stays within +-1.0
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> quat_w <= 16'sd16384 && quat_w >= -16'sd16384)
        else $error("quat_w out of range");

endmodule

// ===== verif/euler_to_quaternion_top_tb.sv =====
module euler_to_quaternion_top_tb;
    import e2q_pkg::*;

    // Timing and stimulus knobs.
    localparam int HALF_PERIOD = 5;
    localparam int RESET_CYCLES = 12;
    localparam int PIPE_LATENCY = 19;
    localparam int CYCLE_LIMIT = 400000;
    localparam int RANDOM_WORDS = 550;

    // Fixed point of the CORDIC and the products.
    localparam int FRAC_Q = 30;
    localparam longint GAIN_Q30 = 64'sd652032874;

    typedef struct {
        logic signed [OUT_WIDTH-1:0] w;
        logic signed [OUT_WIDTH-1:0] x;
        logic signed [OUT_WIDTH-1:0] y;
        logic signed [OUT_WIDTH-1:0] z;
    } quat_t;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    logic signed [ANGLE_WIDTH-1:0] roll_angle;
    logic signed [ANGLE_WIDTH-1:0] pitch_angle;
    logic signed [ANGLE_WIDTH-1:0] yaw_angle;
    logic out_valid;
    logic out_stall;
    logic signed [OUT_WIDTH-1:0] quat_w;
    logic signed [OUT_WIDTH-1:0] quat_x;
    logic signed [OUT_WIDTH-1:0] quat_y;
    logic signed [OUT_WIDTH-1:0] quat_z;

    // Expected quaternions, oldest first.
    quat_t pending_quats[$];
    int error_count;
    int cycle_count;
    // Idle rates in percent for each side.
    int send_idle_pct;
    int recv_idle_pct;

    euler_to_quaternion_top DUT (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .roll_angle(roll_angle),
        .pitch_angle(pitch_angle),
        .yaw_angle(yaw_angle),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .quat_w(quat_w),
        .quat_x(quat_x),
        .quat_y(quat_y),
        .quat_z(quat_z)
    );

    initial clk = 1'b0;
    always #HALF_PERIOD clk = ~clk;

    // floor(v / 2^s); >>> on a signed longint floors already
    function automatic longint floor_shr(input longint v, input int s);
        return v >>> s;
    endfunction

    // Half-angle cosine and sine, Q30, from a rotation-mode CORDIC.
    function automatic void half_angle_cs(input logic signed [ANGLE_WIDTH-1:0] ang,
                                          output longint c, output longint s);
        longint zr;
        longint xr;
        longint yr;
        longint dx;
        longint dy;
        longint da;
        begin
            zr = longint'(ang) * (64'sd1 << (32 - ANGLE_WIDTH));
            xr = GAIN_Q30;
            yr = 0;
            for (int i = 0; i < CORDIC_STAGES && i < 32; i++)
            begin
                dx = floor_shr(yr, i);
                dy = floor_shr(xr, i);
                da = longint'(atan_table(i)) * 2;
                if (zr >= 0)
                begin
                    xr = xr - dx;
                    yr = yr + dy;
                    zr = zr - da;
                end
                else
                begin
                    xr = xr + dx;
                    yr = yr - dy;
                    zr = zr + da;
                end
            end
            c = xr;
            s = yr;
        end
    endfunction

    // Arctangent steps, units of 2*pi/2^32.
    function automatic longint atan_table(input int idx);
        longint steps[32] = '{
            64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4,
            64'h028B0D43, 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55,
            64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
            64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D,
            64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
            64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051,
            64'h00000029, 64'h00000014, 64'h0000000A, 64'h00000005,
            64'h00000003, 64'h00000001, 64'h00000001, 64'h00000000};
        return steps[idx];
    endfunction

    function automatic longint round_pair(input longint a, input longint b);
        return floor_shr(a * b + (64'sd1 << (FRAC_Q - 1)), FRAC_Q);
    endfunction

    // Q60 sum to Q1.14 with round to nearest and clamp to +-1.
    function automatic logic signed [OUT_WIDTH-1:0] to_q14(input longint q60);
        longint v;
        longint unity;
        begin
            unity = 64'sd1 << OUT_FRACTION_BITS;
            v = floor_shr(q60 + (64'sd1 << (2 * FRAC_Q - OUT_FRACTION_BITS - 1)),
                          2 * FRAC_Q - OUT_FRACTION_BITS);
            if (v > unity) v = unity;
            if (v < -unity) v = -unity;
            return v[OUT_WIDTH-1:0];
        end
    endfunction

    function automatic quat_t zyx_quaternion(input logic signed [ANGLE_WIDTH-1:0] r,
                                             input logic signed [ANGLE_WIDTH-1:0] p,
                                             input logic signed [ANGLE_WIDTH-1:0] yw);
        longint cr, sr, cp, sp, cy, sy;
        longint crcp, srsp, srcp, crsp;
        quat_t q;
        begin
            half_angle_cs(r, cr, sr);
            half_angle_cs(p, cp, sp);
            half_angle_cs(yw, cy, sy);
            crcp = round_pair(cr, cp);
            srsp = round_pair(sr, sp);
            srcp = round_pair(sr, cp);
            crsp = round_pair(cr, sp);
            q.w = to_q14(crcp * cy + srsp * sy);
            q.x = to_q14(srcp * cy - crsp * sy);
            q.y = to_q14(crsp * cy + srcp * sy);
            q.z = to_q14(crcp * sy - srsp * cy);
            return q;
        end
    endfunction

    // Drive one angle set and hold it until the block takes it. The
    // prediction goes in the queue at the accepting edge.
    task automatic send_angles(input logic signed [ANGLE_WIDTH-1:0] r,
                               input logic signed [ANGLE_WIDTH-1:0] p,
                               input logic signed [ANGLE_WIDTH-1:0] yw);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        roll_angle <= r;
        pitch_angle <= p;
        yaw_angle <= yw;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pending_quats.insert(pending_quats.size(), zyx_quaternion(r, p, yw));
    endtask

    // Lower valid once the last word of a phase is in.
    task automatic drop_valid();
        in_valid <= 1'b0;
    endtask

    // Receiver: random stall, driven at the rising edge.
    always @(posedge clk)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
            out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // Result checker: compare each accepted word with the oldest prediction.
    always @(posedge clk)
    begin
        quat_t exp_q;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_quats.size() == 0)
            begin
                error_count++;
                $display("%0t: unexpected word w=%0d x=%0d y=%0d z=%0d",
                         $time, quat_w, quat_x, quat_y, quat_z);
            end
            else
            begin
                exp_q = pending_quats.pop_front();
                if (quat_w !== exp_q.w)
                begin
                    error_count++;
                    $display("%0t: quat_w expected %0d actual %0d", $time, exp_q.w, quat_w);
                end
                if (quat_x !== exp_q.x)
                begin
                    error_count++;
                    $display("%0t: quat_x expected %0d actual %0d", $time, exp_q.x, quat_x);
                end
                if (quat_y !== exp_q.y)
                begin
                    error_count++;
                    $display("%0t: quat_y expected %0d actual %0d", $time, exp_q.y, quat_y);
                end
                if (quat_z !== exp_q.z)
                begin
                    error_count++;
                    $display("%0t: quat_z expected %0d actual %0d", $time, exp_q.z, quat_z);
                end
            end
        end
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Extremes, zero, quarter turns and the -pi half-angle corner.
    task automatic test_directed_angles();
        logic signed [ANGLE_WIDTH-1:0] corners[8] = '{
            16'sh0000, 16'sh7FFF, -16'sh8000, 16'sh4000,
            -16'sh4000, 16'sh0001, -16'sh0001, 16'sh2000};
        send_angles(16'sh0000, 16'sh0000, 16'sh0000);
        for (int i = 0; i < 8; i++)
            send_angles(corners[i], corners[(i + 3) % 8], corners[(i + 5) % 8]);
        send_angles(-16'sh8000, -16'sh8000, -16'sh8000);
        send_angles(16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
        send_angles(16'sh5555, -16'sh5556, 16'shAAAA);
        send_angles(16'shFFFF, 16'sh0000, 16'sh8000);
        for (int i = 0; i < ANGLE_WIDTH; i += 2)
            send_angles(16'sh1 << i, -(16'sh1 << (i + 1)), 16'sh1 << (15 - i));
        drop_valid();
    endtask

    // Full-range random angles, with some clustered near the poles.
    task automatic test_random_angles(input int count);
        logic signed [ANGLE_WIDTH-1:0] r, p, yw;
        for (int n = 0; n < count; n++)
        begin
            r = ANGLE_WIDTH'($urandom);
            yw = ANGLE_WIDTH'($urandom);
            if ($urandom_range(9) == 0)
                p = 16'sh4000 + $signed(16'($urandom_range(64))) - 16'sd32;
            else
                p = ANGLE_WIDTH'($urandom);
            send_angles(r, p, yw);
        end
        drop_valid();
    endtask

    // Wait for the pipe to empty, then idle for longer than the pipe latency.
    task automatic drain_pipe();
        while (pending_quats.size() != 0)
            @(posedge clk);
        repeat (PIPE_LATENCY + 4) @(posedge clk);
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        roll_angle = '0;
        pitch_angle = '0;
        yaw_angle = '0;
        error_count = 0;
        cycle_count = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // sender idles lightly, receiver stalls hard
        send_idle_pct = 21;
        recv_idle_pct = 81;
        test_directed_angles();
        test_random_angles(RANDOM_WORDS / 3);

        // swapped
        send_idle_pct = 81;
        recv_idle_pct = 21;
        test_random_angles(RANDOM_WORDS / 3);

        // full rate both ways
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_angles(RANDOM_WORDS - 2 * (RANDOM_WORDS / 3));

        drain_pipe();
        if (error_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
